@@ design/sps_pkg.sv @@
// Shared types, constants and phase tables for the stepper phase sequencer.
package sps_pkg;

  localparam int POSITION_BITS = 16;
  localparam int INTERVAL_BITS = 26;
  localparam int MOVE_BITS     = 16;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS =
    (INTERVAL_BITS > POSITION_BITS) ? INTERVAL_BITS : POSITION_BITS;

  // Register indexes on the configuration port
  localparam logic [CFG_INDEX_BITS-1:0] REG_DRIVE_MODE    = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_STEPS_PER_REV = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_STEP_INTERVAL = 2'd2;

  // Input item codes
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_MOVE = 1'b1;

  localparam logic [POSITION_BITS-1:0] STEPS_PER_REV_RESET = POSITION_BITS'(200);
  localparam logic [INTERVAL_BITS-1:0] STEP_INTERVAL_RESET = INTERVAL_BITS'(1000);

  typedef enum logic [1:0] {
    MODE_ONE_PHASE = 2'd0,
    MODE_TWO_PHASE = 2'd1,
    MODE_HALF_STEP = 2'd2
  } drive_mode_t;

  // Pin word layout: {dir_a, dir_b, current_a, current_b}
  localparam logic [3:0] TBL_ONE  [4] = '{4'h5, 4'h2, 4'h9, 4'hE};
  localparam logic [3:0] TBL_TWO  [4] = '{4'h7, 4'h3, 4'hB, 4'hF};
  localparam logic [3:0] TBL_HALF [8] = '{4'h5, 4'h7, 4'h2, 4'h3,
                                          4'h9, 4'hB, 4'hE, 4'hF};

  typedef struct packed {
    logic [1:0]               drive_mode;
    logic [POSITION_BITS-1:0] steps_per_rev;
    logic [INTERVAL_BITS-1:0] step_interval;
  } cfg_t;

  // Pin levels for a position; the unused mode keeps the old levels.
  function automatic logic [3:0] pin_lookup(input logic [1:0] mode,
                                            input logic [2:0] phase,
                                            input logic [3:0] pins_old);
    logic [3:0] pins;
    pins = pins_old;
    case (mode)
      MODE_ONE_PHASE: pins = TBL_ONE[phase[1:0]];
      MODE_TWO_PHASE: pins = TBL_TWO[phase[1:0]];
      MODE_HALF_STEP: pins = TBL_HALF[phase];
      default:        pins = pins_old;
    endcase
    return pins;
  endfunction

endpackage

@@ design/sps_config.sv @@
// Configuration register bank for the stepper phase sequencer.
module sps_config (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [sps_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [sps_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  output sps_pkg::cfg_t                     cfg
);
  import sps_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.drive_mode    <= MODE_ONE_PHASE;
      cfg.steps_per_rev <= STEPS_PER_REV_RESET;
      cfg.step_interval <= STEP_INTERVAL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_DRIVE_MODE:    cfg.drive_mode    <= cfg_data[1:0];
        REG_STEPS_PER_REV: cfg.steps_per_rev <= cfg_data[POSITION_BITS-1:0];
        REG_STEP_INTERVAL: cfg.step_interval <= cfg_data[INTERVAL_BITS-1:0];
        default: ;
      endcase
    end
  end

endmodule

@@ design/sps_advance.sv @@
// One-step position advance with revolution wrap and phase pin lookup.
module sps_advance (
  input  sps_pkg::cfg_t                     cfg,
  input  logic [sps_pkg::POSITION_BITS-1:0] pos,
  input  logic                              forward,
  input  logic [3:0]                        pins,
  output logic [sps_pkg::POSITION_BITS-1:0] pos_next,
  output logic [3:0]                        pins_next
);
  import sps_pkg::*;

  logic [POSITION_BITS:0] wrap;
  logic [POSITION_BITS:0] wrap_last;
  logic [POSITION_BITS:0] pos_ext;

  always_comb begin
    // Zero steps per revolution means the full position range
    wrap      = (cfg.steps_per_rev == '0) ? {1'b1, {POSITION_BITS{1'b0}}}
                                          : {1'b0, cfg.steps_per_rev};
    wrap_last = wrap - 1'b1;
    pos_ext   = {1'b0, pos};
    if (forward) begin
      pos_next = (pos_ext >= wrap_last) ? '0 : pos + 1'b1;
    end else begin
      pos_next = (pos == '0 || pos_ext >= wrap) ? wrap_last[POSITION_BITS-1:0]
                                                : pos - 1'b1;
    end
    pins_next = pin_lookup(cfg.drive_mode, pos_next[2:0], pins);
  end

endmodule

@@ design/stepper_phase_sequencer.sv @@
// Top level of the stepper phase sequencer: item pipeline, motion state, result register.
//
//  channel | signals                                   | beat taken when
//  --------+-------------------------------------------+-------------------------
//  in      | in_valid, in_stall, op, move_steps        | in_valid && !in_stall
//  out     | out_valid, out_stall, dir_a .. position   | out_valid && !out_stall
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | cfg_valid && cfg_ready
//
// One beat per cycle sustained while out does not stall; a beat taken on in is held in
// the input register, moves into the result register and leaves on out from there.
// Between the two registers: saturating tick count, interval compare, wrap step, lookup.
// Reset (rst, synchronous) clears the motion state and pins, loads register defaults.
// A stall on out holds the result register and backs up into in_stall only when
// the input register is also full.
module stepper_phase_sequencer (
  input  logic                               clk,
  input  logic                               rst,
  // item input
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               op,
  input  logic signed [sps_pkg::MOVE_BITS-1:0] move_steps,
  // result output
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               dir_a,
  output logic                               dir_b,
  output logic                               current_a,
  output logic                               current_b,
  output logic                               brake,
  output logic                               busy_res,
  output logic                               stepped,
  output logic [sps_pkg::POSITION_BITS-1:0]  position,
  // configuration writes
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [sps_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [sps_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  import sps_pkg::*;

  localparam logic [INTERVAL_BITS-1:0] TICKS_MAX = '1;

  cfg_t cfg;

  // Input register
  logic                 in_full;
  logic                 in_full_next;
  logic                 op_q;
  logic [MOVE_BITS-1:0] steps_q;

  // Motion state
  logic [POSITION_BITS-1:0] step_position;
  logic [MOVE_BITS-1:0]     steps_remaining;
  logic                     move_forward;
  logic [INTERVAL_BITS-1:0] elapsed_ticks;
  logic [3:0]               pin_levels;

  logic [POSITION_BITS-1:0] step_position_next;
  logic [MOVE_BITS-1:0]     steps_remaining_next;
  logic                     move_forward_next;
  logic [INTERVAL_BITS-1:0] elapsed_ticks_next;
  logic [3:0]               pin_levels_next;
  logic                     stepped_next;

  logic [POSITION_BITS-1:0] adv_pos;
  logic [3:0]               adv_pins;
  logic [INTERVAL_BITS-1:0] ticks_inc;

  logic res_ready;
  logic in_take;
  logic work;

  sps_config u_config (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  sps_advance u_advance (
    .cfg       (cfg),
    .pos       (step_position),
    .forward   (move_forward),
    .pins      (pin_levels),
    .pos_next  (adv_pos),
    .pins_next (adv_pins)
  );

  // Result register is free when empty or being drained this cycle
  assign res_ready    = !out_valid || !out_stall;
  assign work         = in_full && res_ready;
  assign in_stall     = in_full && !res_ready;
  assign in_take      = in_valid && !in_stall;
  assign in_full_next = in_take || (in_full && !res_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else begin
      in_full <= in_full_next;
    end
  end

  // Hold the payload while stalled
  always_ff @(posedge clk) begin
    if (in_take) begin
      op_q    <= op;
      steps_q <= move_steps;
    end
  end

  // Apply one item to the motion state
  always_comb begin
    step_position_next   = step_position;
    steps_remaining_next = steps_remaining;
    move_forward_next    = move_forward;
    elapsed_ticks_next   = elapsed_ticks;
    pin_levels_next      = pin_levels;
    stepped_next         = 1'b0;
    ticks_inc            = (elapsed_ticks != TICKS_MAX) ? elapsed_ticks + 1'b1
                                                        : elapsed_ticks;
    if (op_q == OP_MOVE) begin
      // Zero move leaves direction; the negate of the most negative
      // count is its own magnitude in unsigned terms
      if (steps_q == '0) begin
        steps_remaining_next = '0;
      end else if (steps_q[MOVE_BITS-1]) begin
        move_forward_next    = 1'b0;
        steps_remaining_next = '0 - steps_q;
      end else begin
        move_forward_next    = 1'b1;
        steps_remaining_next = steps_q;
      end
    end else begin
      elapsed_ticks_next = ticks_inc;
      if (steps_remaining != '0 && ticks_inc >= cfg.step_interval) begin
        elapsed_ticks_next   = '0;
        steps_remaining_next = steps_remaining - 1'b1;
        step_position_next   = adv_pos;
        pin_levels_next      = adv_pins;
        stepped_next         = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_position   <= '0;
      steps_remaining <= '0;
      move_forward    <= 1'b0;
      elapsed_ticks   <= '0;
      pin_levels      <= '0;
    end else if (work) begin
      step_position   <= step_position_next;
      steps_remaining <= steps_remaining_next;
      move_forward    <= move_forward_next;
      elapsed_ticks   <= elapsed_ticks_next;
      pin_levels      <= pin_levels_next;
    end
  end

  // Result register: advance on work, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (work) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (work) begin
      dir_a     <= pin_levels_next[3];
      dir_b     <= pin_levels_next[2];
      current_a <= pin_levels_next[1];
      current_b <= pin_levels_next[0];
      brake     <= (steps_remaining_next == '0);
      busy_res  <= (steps_remaining_next != '0);
      stepped   <= stepped_next;
      position  <= step_position_next;
    end
  end

endmodule
